// ===== rtl/lstmas_pkg.sv =====
// Shared types and constants of the lazy segment tree block.
`default_nettype none

package lstmas_pkg;

   // Field widths fixed by the interface.
   localparam int VW   = 31;
   localparam int CNTW = 11;

   // Operation codes of an input beat.
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_MUL   = 2'd1;
   localparam logic [1:0] OP_ADD   = 2'd2;
   localparam logic [1:0] OP_QUERY = 2'd3;

   // Configuration register indexes.
   localparam logic REG_MODULUS = 1'b0;
   localparam logic REG_COUNT   = 1'b1;

   // Modular multiply-add jobs: each names its operands and its destination.
   localparam logic [2:0] MM_VAL     = 3'd0;
   localparam logic [2:0] MM_PD_MUL  = 3'd1;
   localparam logic [2:0] MM_PD_ADD  = 3'd2;
   localparam logic [2:0] MM_AP_SUM1 = 3'd3;
   localparam logic [2:0] MM_AP_SUM2 = 3'd4;
   localparam logic [2:0] MM_AP_MUL  = 3'd5;
   localparam logic [2:0] MM_AP_ADD  = 3'd6;
   localparam logic [2:0] MM_QRY     = 3'd7;

   // Sources of a node memory write.
   localparam logic [1:0] WR_APPLY   = 2'd0;
   localparam logic [1:0] WR_CLEAR   = 2'd1;
   localparam logic [1:0] WR_PARENT  = 2'd2;
   localparam logic [1:0] WR_COMBINE = 2'd3;

   // Tag pair used by an apply step.
   localparam logic TAG_OP = 1'b0;
   localparam logic TAG_PD = 1'b1;

   // One node of the tree as stored in memory.
   typedef struct packed {
      logic [VW-1:0] sum;
      logic [VW-1:0] mul;
      logic [VW-1:0] add;
   } node_word_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       mem_rd;
      logic       mem_wr;
      logic [1:0] wr_src;
      logic       mm_start;
      logic [2:0] mm_op;
      logic       tag_sel;
      logic       clr_acc;
      logic       save_left;
      logic [1:0] op;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic mm_done;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/lazy_segment_tree_mul_add_sum_top.sv =====
// Top level of the lazy segment tree with range multiply, range add and range sum.
`default_nettype none

// Keeps LEAVES elements modulo a configured modulus in a lazy-propagation segment
// tree of 4*LEAVES nodes held in one single-port memory. After reset a clearing pass
// initialises the memory; no beat is accepted meanwhile. Every modular product runs
// on one bit-serial multiply-add unit. An item therefore runs 1 + 10P + 4A + Q
// products plus the memory steps of each visited node. P is the number of nodes
// pushed down, which costs two products for the tags and four for each child. A is
// the number of fully covered nodes updated, and Q the number of covered nodes
// summed. Items are handled one at a time; a new beat is taken while a finished
// sum still waits on the result side. Only a query returns a beat.

module lazy_segment_tree_mul_add_sum_top #(
   parameter int LEAVES = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_op,
   input  wire logic [lstmas_pkg::CNTW-1:0]   req_left,
   input  wire logic [lstmas_pkg::CNTW-1:0]   req_right,
   input  wire logic [lstmas_pkg::VW-1:0]     req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [lstmas_pkg::VW-1:0]          rsp_range_sum,
   input  wire logic                          csr_we,
   input  wire logic                          csr_index,
   input  wire logic [lstmas_pkg::VW-1:0]     csr_wdata
);

   localparam int VW   = lstmas_pkg::VW;
   localparam int CNTW = lstmas_pkg::CNTW;
   localparam int AW   = $clog2(4 * LEAVES);
   localparam int LW   = $clog2(LEAVES + 1);
   localparam int CW   = (LW > CNTW) ? LW : CNTW;

   logic [VW-1:0]   modulus_ff;
   logic [CNTW-1:0] count_ff;
   logic            rsp_valid_ff;
   logic [VW-1:0]   rsp_sum_ff;

   logic [VW-1:0] meff;
   logic [LW-1:0] limit;
   logic          rsp_busy;
   logic          rsp_load;
   logic [AW-1:0] addr;
   logic [LW-1:0] len;
   logic [VW-1:0] acc;

   lstmas_pkg::dp_cmd_type    cmd;
   lstmas_pkg::dp_status_type status;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= VW'(2147483647);
         count_ff   <= CNTW'(1024);
      end else if (csr_we) begin
         if (csr_index == lstmas_pkg::REG_MODULUS) begin
            modulus_ff <= csr_wdata;
         end else if (csr_index == lstmas_pkg::REG_COUNT) begin
            count_ff <= csr_wdata[CNTW-1:0];
         end
      end
   end

   // Effective modulus and element limit.
   always_comb begin
      meff  = (modulus_ff < VW'(2)) ? VW'(1) : modulus_ff;
      limit = (CW'(count_ff) > CW'(LEAVES)) ? LW'(LEAVES) : LW'(count_ff);
   end

   // Result register: holds a sum until its beat is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_sum_ff <= acc;
      end
   end

   assign rsp_busy      = rsp_valid_ff && !rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = rsp_sum_ff;

   lstmas_ctrl #(
      .LEAVES (LEAVES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .req_left  (req_left),
      .req_right (req_right),
      .limit     (limit),
      .rsp_busy  (rsp_busy),
      .rsp_load  (rsp_load),
      .cmd       (cmd),
      .addr      (addr),
      .len       (len),
      .status    (status)
   );

   lstmas_datapath #(
      .LEAVES (LEAVES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .addr      (addr),
      .len       (len),
      .req_value (req_value),
      .meff      (meff),
      .status    (status),
      .acc       (acc)
   );

endmodule

`default_nettype wire

// ===== rtl/lstmas_mulmod.sv =====
// Bit-serial modular multiply-add unit: result = (x * y + z) mod m.
`default_nettype none

module lstmas_mulmod (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [lstmas_pkg::VW-1:0] x,
   input  wire logic [lstmas_pkg::VW-1:0] y,
   input  wire logic [lstmas_pkg::VW-1:0] z,
   input  wire logic [lstmas_pkg::VW-1:0] m,
   output logic                           done,
   output logic [lstmas_pkg::VW-1:0]      result
);

   localparam int VW = lstmas_pkg::VW;
   localparam int CW = $clog2(VW);

   logic          busy_ff;
   logic          fin_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [VW-1:0] xs_ff;
   logic [VW-1:0] ys_ff;
   logic [VW-1:0] zs_ff;
   logic [VW-1:0] r_ff;

   logic [VW+1:0] t0;
   logic [VW+1:0] t1;
   logic [VW+1:0] t2;
   logic [VW:0]   f0;
   logic [VW:0]   f1;

   // One Horner step: double, add the multiplicand if the bit is set, reduce twice.
   always_comb begin
      t0 = {1'b0, r_ff, 1'b0} + (xs_ff[VW-1] ? {2'b00, ys_ff} : '0);
      t1 = (t0 >= {2'b00, m}) ? t0 - {2'b00, m} : t0;
      t2 = (t1 >= {2'b00, m}) ? t1 - {2'b00, m} : t1;
      f0 = {1'b0, r_ff} + {1'b0, zs_ff};
      f1 = (f0 >= {1'b0, m}) ? f0 - {1'b0, m} : f0;
   end

   // Sequencing of the steps and the final addition.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            fin_ff  <= 1'b1;
         end else if (fin_ff) begin
            fin_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Operand and remainder registers.
   always_ff @(posedge clock) begin
      if (start) begin
         xs_ff  <= x;
         ys_ff  <= y;
         zs_ff  <= z;
         r_ff   <= '0;
         cnt_ff <= CW'(VW - 1);
      end else if (busy_ff) begin
         xs_ff  <= {xs_ff[VW-2:0], 1'b0};
         r_ff   <= t2[VW-1:0];
         cnt_ff <= cnt_ff - CW'(1);
      end else if (fin_ff) begin
         r_ff <= f1[VW-1:0];
      end
   end

   assign done   = done_ff;
   assign result = r_ff;

endmodule

`default_nettype wire

// ===== rtl/lstmas_datapath.sv =====
// Datapath: node memory, tag and sum registers and the modular arithmetic unit.
`default_nettype none

module lstmas_datapath #(
   parameter  int LEAVES = 1024,
   localparam int AW     = $clog2(4 * LEAVES),
   localparam int LW     = $clog2(LEAVES + 1)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire lstmas_pkg::dp_cmd_type     cmd,
   input  wire logic [AW-1:0]              addr,
   input  wire logic [LW-1:0]              len,
   input  wire logic [lstmas_pkg::VW-1:0]  req_value,
   input  wire logic [lstmas_pkg::VW-1:0]  meff,
   output lstmas_pkg::dp_status_type       status,
   output logic [lstmas_pkg::VW-1:0]       acc
);

   localparam int VW    = lstmas_pkg::VW;
   localparam int NODES = 4 * LEAVES;

   lstmas_pkg::node_word_type mem [NODES];
   lstmas_pkg::node_word_type rdata_ff;
   lstmas_pkg::node_word_type wdata;

   logic [VW-1:0] w_sum_ff;
   logic [VW-1:0] w_mul_ff;
   logic [VW-1:0] w_add_ff;
   logic [VW-1:0] pd_mul_ff;
   logic [VW-1:0] pd_add_ff;
   logic [VW-1:0] val_ff;
   logic [VW-1:0] acc_ff;
   logic [VW-1:0] tmp_ff;
   logic [2:0]    tgt_ff;

   logic [VW-1:0] one_m;
   logic [VW-1:0] op_mul;
   logic [VW-1:0] op_add;
   logic [VW-1:0] amul;
   logic [VW-1:0] aadd;
   logic [VW-1:0] mm_x;
   logic [VW-1:0] mm_y;
   logic [VW-1:0] mm_z;
   logic [VW:0]   csum0;
   logic [VW:0]   csum1;
   logic          mm_done;
   logic [VW-1:0] mm_result;

   // One reduced by the modulus: zero when the modulus acts as one.
   assign one_m = {{(VW-1){1'b0}}, meff != VW'(1)};

   // Tag pair that the current operation applies.
   always_comb begin
      case (cmd.op)
         lstmas_pkg::OP_WRITE: begin
            op_mul = '0;
            op_add = val_ff;
         end
         lstmas_pkg::OP_MUL: begin
            op_mul = val_ff;
            op_add = '0;
         end
         default: begin
            op_mul = one_m;
            op_add = val_ff;
         end
      endcase
      amul = (cmd.tag_sel == lstmas_pkg::TAG_PD) ? pd_mul_ff : op_mul;
      aadd = (cmd.tag_sel == lstmas_pkg::TAG_PD) ? pd_add_ff : op_add;
   end

   // Operands of each arithmetic job.
   always_comb begin
      mm_x = '0;
      mm_y = '0;
      mm_z = '0;
      case (cmd.mm_op)
         lstmas_pkg::MM_VAL: begin
            mm_x = req_value;
            mm_y = one_m;
         end
         lstmas_pkg::MM_PD_MUL: begin
            mm_x = rdata_ff.mul;
            mm_y = one_m;
         end
         lstmas_pkg::MM_PD_ADD: begin
            mm_x = rdata_ff.add;
            mm_y = one_m;
         end
         lstmas_pkg::MM_AP_SUM1: begin
            mm_x = rdata_ff.sum;
            mm_y = amul;
         end
         lstmas_pkg::MM_AP_SUM2: begin
            mm_x = VW'(len);
            mm_y = aadd;
            mm_z = w_sum_ff;
         end
         lstmas_pkg::MM_AP_MUL: begin
            mm_x = rdata_ff.mul;
            mm_y = amul;
         end
         lstmas_pkg::MM_AP_ADD: begin
            mm_x = rdata_ff.add;
            mm_y = amul;
            mm_z = aadd;
         end
         default: begin
            mm_x = rdata_ff.sum;
            mm_y = one_m;
            mm_z = acc_ff;
         end
      endcase
   end

   lstmas_mulmod u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mm_start),
      .x      (mm_x),
      .y      (mm_y),
      .z      (mm_z),
      .m      (meff),
      .done   (mm_done),
      .result (mm_result)
   );

   // Write data: applied node, cleared node, pushed parent or recombined parent.
   always_comb begin
      csum0 = {1'b0, tmp_ff} + {1'b0, rdata_ff.sum};
      csum1 = (csum0 >= {1'b0, meff}) ? csum0 - {1'b0, meff} : csum0;
      case (cmd.wr_src)
         lstmas_pkg::WR_APPLY:  wdata = '{sum: w_sum_ff, mul: w_mul_ff, add: w_add_ff};
         lstmas_pkg::WR_CLEAR:  wdata = '{sum: '0, mul: VW'(1), add: '0};
         lstmas_pkg::WR_PARENT: wdata = '{sum: rdata_ff.sum, mul: VW'(1), add: '0};
         default:               wdata = '{sum: csum1[VW-1:0], mul: VW'(1), add: '0};
      endcase
   end

   // Node memory with registered read.
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[addr] <= wdata;
      end
      if (cmd.mem_rd) begin
         rdata_ff <= mem[addr];
      end
   end

   // Working registers and capture of arithmetic results.
   always_ff @(posedge clock) begin
      if (cmd.mm_start) begin
         tgt_ff <= cmd.mm_op;
      end
      if (cmd.save_left) begin
         tmp_ff <= rdata_ff.sum;
      end
      if (cmd.clr_acc) begin
         acc_ff <= '0;
      end else if (mm_done) begin
         case (tgt_ff) inside
            lstmas_pkg::MM_VAL:                         val_ff    <= mm_result;
            lstmas_pkg::MM_PD_MUL:                      pd_mul_ff <= mm_result;
            lstmas_pkg::MM_PD_ADD:                      pd_add_ff <= mm_result;
            lstmas_pkg::MM_AP_SUM1, lstmas_pkg::MM_AP_SUM2: w_sum_ff <= mm_result;
            lstmas_pkg::MM_AP_MUL:                      w_mul_ff  <= mm_result;
            lstmas_pkg::MM_AP_ADD:                      w_add_ff  <= mm_result;
            default:                                    acc_ff    <= mm_result;
         endcase
      end
   end

   assign status.mm_done = mm_done;
   assign acc            = acc_ff;

endmodule

`default_nettype wire

// ===== rtl/lstmas_ctrl.sv =====
// Controller: clearing pass, tree walk with an explicit stack and command sequencing.
`default_nettype none

module lstmas_ctrl #(
   parameter  int LEAVES = 1024,
   localparam int AW     = $clog2(4 * LEAVES),
   localparam int LW     = $clog2(LEAVES + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_op,
   input  wire logic [lstmas_pkg::CNTW-1:0]   req_left,
   input  wire logic [lstmas_pkg::CNTW-1:0]   req_right,
   input  wire logic [LW-1:0]                 limit,
   input  wire logic                          rsp_busy,
   output logic                               rsp_load,
   output lstmas_pkg::dp_cmd_type             cmd,
   output logic [AW-1:0]                      addr,
   output logic [LW-1:0]                      len,
   input  wire lstmas_pkg::dp_status_type     status
);

   localparam int CNTW  = lstmas_pkg::CNTW;
   localparam int CW    = (LW > CNTW) ? LW : CNTW;
   localparam int NODES = 4 * LEAVES;
   localparam int SD    = $clog2(LEAVES) + 1;
   localparam int SPW   = $clog2(SD + 1);
   localparam int IXW   = $clog2(SD);
   localparam logic [LW-1:0] LEAVES_W = LW'(LEAVES);

   localparam logic [4:0] S_CLEAR  = 5'd0;
   localparam logic [4:0] S_IDLE   = 5'd1;
   localparam logic [4:0] S_MMWAIT = 5'd2;
   localparam logic [4:0] S_VISIT  = 5'd3;
   localparam logic [4:0] S_Q_RD   = 5'd4;
   localparam logic [4:0] S_AP_RD  = 5'd5;
   localparam logic [4:0] S_AP_S1  = 5'd6;
   localparam logic [4:0] S_AP_S2  = 5'd7;
   localparam logic [4:0] S_AP_M   = 5'd8;
   localparam logic [4:0] S_AP_A   = 5'd9;
   localparam logic [4:0] S_AP_WR  = 5'd10;
   localparam logic [4:0] S_PD_RD  = 5'd11;
   localparam logic [4:0] S_PD_M   = 5'd12;
   localparam logic [4:0] S_PD_A   = 5'd13;
   localparam logic [4:0] S_PD_WP  = 5'd14;
   localparam logic [4:0] S_DESC   = 5'd15;
   localparam logic [4:0] S_RET    = 5'd16;
   localparam logic [4:0] S_CB_R0  = 5'd17;
   localparam logic [4:0] S_CB_R1  = 5'd18;
   localparam logic [4:0] S_CB_WR  = 5'd19;
   localparam logic [4:0] S_DONE   = 5'd20;

   // What follows an apply step.
   localparam logic [1:0] AP_LEAF = 2'd0;
   localparam logic [1:0] AP_CH0  = 2'd1;
   localparam logic [1:0] AP_CH1  = 2'd2;

   logic [4:0]    state_ff, state_in;
   logic [4:0]    ret_ff, ret_in;
   logic [1:0]    op_ff, op_in;
   logic [LW-1:0] a_ff, a_in;
   logic [LW-1:0] b_ff, b_in;
   logic [AW-1:0] cur_node_ff, cur_node_in;
   logic [LW-1:0] cur_lo_ff, cur_lo_in;
   logic [LW-1:0] cur_hi_ff, cur_hi_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [AW-1:0] ap_addr_ff, ap_addr_in;
   logic [LW-1:0] ap_len_ff, ap_len_in;
   logic          ap_tsel_ff, ap_tsel_in;
   logic [1:0]    ap_phase_ff, ap_phase_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   logic [AW-1:0] stk_node_ff [SD];
   logic [LW-1:0] stk_lo_ff   [SD];
   logic [LW-1:0] stk_hi_ff   [SD];
   logic          stk_ph_ff   [SD];

   logic           push;
   logic           mark;
   logic [SPW-1:0] spm1;
   logic [IXW-1:0] top_ix;
   logic [IXW-1:0] sp_ix;
   logic [AW-1:0]  top_node;
   logic [LW-1:0]  top_lo;
   logic [LW-1:0]  top_hi;
   logic           top_ph;
   logic [LW:0]    top_msum;
   logic [LW-1:0]  top_mid;
   logic [LW:0]    msum;
   logic [LW-1:0]  mid;
   logic [AW-1:0]  child0;
   logic [AW-1:0]  child1;
   logic           disjoint;
   logic           covered;

   logic [CW-1:0]   lim_c;
   logic [CW-1:0]   lft_c;
   logic [CNTW-1:0] rgt_raw;
   logic [CW-1:0]   rgt_c;
   logic            empty;

   // Range clipping of the incoming beat.
   always_comb begin
      lim_c   = CW'(limit);
      lft_c   = (req_left == '0) ? CW'(1) : CW'(req_left);
      rgt_raw = (req_op == lstmas_pkg::OP_WRITE) ? req_left : req_right;
      rgt_c   = (CW'(rgt_raw) > lim_c) ? lim_c : CW'(rgt_raw);
      empty   = (lim_c == '0) || (lft_c > rgt_c);
   end

   // Geometry of the current node and of the top stack frame.
   always_comb begin
      msum     = {1'b0, cur_lo_ff} + {1'b0, cur_hi_ff};
      mid      = msum[LW:1];
      child0   = {cur_node_ff[AW-2:0], 1'b0};
      child1   = {cur_node_ff[AW-2:0], 1'b1};
      disjoint = (a_ff > cur_hi_ff) || (b_ff < cur_lo_ff);
      covered  = (a_ff <= cur_lo_ff) && (b_ff >= cur_hi_ff);
      spm1     = sp_ff - SPW'(1);
      top_ix   = spm1[IXW-1:0];
      sp_ix    = sp_ff[IXW-1:0];
      top_node = stk_node_ff[top_ix];
      top_lo   = stk_lo_ff[top_ix];
      top_hi   = stk_hi_ff[top_ix];
      top_ph   = stk_ph_ff[top_ix];
      top_msum = {1'b0, top_lo} + {1'b0, top_hi};
      top_mid  = top_msum[LW:1];
   end

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      op_in       = op_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      cur_node_in = cur_node_ff;
      cur_lo_in   = cur_lo_ff;
      cur_hi_in   = cur_hi_ff;
      sp_in       = sp_ff;
      ap_addr_in  = ap_addr_ff;
      ap_len_in   = ap_len_ff;
      ap_tsel_in  = ap_tsel_ff;
      ap_phase_in = ap_phase_ff;
      clr_addr_in = clr_addr_ff;
      push        = 1'b0;
      mark        = 1'b0;
      req_ready   = 1'b0;
      rsp_load    = 1'b0;
      cmd         = '0;
      cmd.op      = op_ff;
      cmd.tag_sel = ap_tsel_ff;
      addr        = cur_node_ff;
      len         = ap_len_ff;

      unique case (state_ff)
         S_CLEAR: begin
            cmd.mem_wr = 1'b1;
            cmd.wr_src = lstmas_pkg::WR_CLEAR;
            addr       = clr_addr_ff;
            if (clr_addr_ff == AW'(NODES - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + AW'(1);
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in       = req_op;
               a_in        = lft_c[LW-1:0];
               b_in        = rgt_c[LW-1:0];
               cmd.clr_acc = 1'b1;
               if (empty) begin
                  state_in = (req_op == lstmas_pkg::OP_QUERY) ? S_DONE : S_IDLE;
               end else begin
                  cmd.mm_start = 1'b1;
                  cmd.mm_op    = lstmas_pkg::MM_VAL;
                  ret_in       = S_VISIT;
                  cur_node_in  = AW'(1);
                  cur_lo_in    = LW'(1);
                  cur_hi_in    = LEAVES_W;
                  sp_in        = '0;
                  state_in     = S_MMWAIT;
               end
            end
         end
         S_MMWAIT: begin
            if (status.mm_done) begin
               state_in = ret_ff;
            end
         end
         S_VISIT: begin
            if (disjoint) begin
               state_in = S_RET;
            end else if (covered && op_ff == lstmas_pkg::OP_QUERY) begin
               cmd.mem_rd = 1'b1;
               state_in   = S_Q_RD;
            end else if (covered) begin
               ap_addr_in  = cur_node_ff;
               ap_len_in   = cur_hi_ff - cur_lo_ff + LW'(1);
               ap_tsel_in  = lstmas_pkg::TAG_OP;
               ap_phase_in = AP_LEAF;
               state_in    = S_AP_RD;
            end else begin
               state_in = S_PD_RD;
            end
         end
         S_Q_RD: begin
            cmd.mm_start = 1'b1;
            cmd.mm_op    = lstmas_pkg::MM_QRY;
            ret_in       = S_RET;
            state_in     = S_MMWAIT;
         end
         S_AP_RD: begin
            cmd.mem_rd = 1'b1;
            addr       = ap_addr_ff;
            state_in   = S_AP_S1;
         end
         S_AP_S1: begin
            cmd.mm_start = 1'b1;
            cmd.mm_op    = lstmas_pkg::MM_AP_SUM1;
            ret_in       = S_AP_S2;
            state_in     = S_MMWAIT;
         end
         S_AP_S2: begin
            cmd.mm_start = 1'b1;
            cmd.mm_op    = lstmas_pkg::MM_AP_SUM2;
            ret_in       = S_AP_M;
            state_in     = S_MMWAIT;
         end
         S_AP_M: begin
            cmd.mm_start = 1'b1;
            cmd.mm_op    = lstmas_pkg::MM_AP_MUL;
            ret_in       = S_AP_A;
            state_in     = S_MMWAIT;
         end
         S_AP_A: begin
            cmd.mm_start = 1'b1;
            cmd.mm_op    = lstmas_pkg::MM_AP_ADD;
            ret_in       = S_AP_WR;
            state_in     = S_MMWAIT;
         end
         S_AP_WR: begin
            cmd.mem_wr = 1'b1;
            cmd.wr_src = lstmas_pkg::WR_APPLY;
            addr       = ap_addr_ff;
            if (ap_phase_ff == AP_CH0) begin
               ap_addr_in  = child1;
               ap_len_in   = cur_hi_ff - mid;
               ap_phase_in = AP_CH1;
               state_in    = S_AP_RD;
            end else if (ap_phase_ff == AP_CH1) begin
               state_in = S_DESC;
            end else begin
               state_in = S_RET;
            end
         end
         S_PD_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_PD_M;
         end
         S_PD_M: begin
            cmd.mm_start = 1'b1;
            cmd.mm_op    = lstmas_pkg::MM_PD_MUL;
            ret_in       = S_PD_A;
            state_in     = S_MMWAIT;
         end
         S_PD_A: begin
            cmd.mm_start = 1'b1;
            cmd.mm_op    = lstmas_pkg::MM_PD_ADD;
            ret_in       = S_PD_WP;
            state_in     = S_MMWAIT;
         end
         S_PD_WP: begin
            cmd.mem_wr  = 1'b1;
            cmd.wr_src  = lstmas_pkg::WR_PARENT;
            ap_addr_in  = child0;
            ap_len_in   = mid - cur_lo_ff + LW'(1);
            ap_tsel_in  = lstmas_pkg::TAG_PD;
            ap_phase_in = AP_CH0;
            state_in    = S_AP_RD;
         end
         S_DESC: begin
            push        = 1'b1;
            sp_in       = sp_ff + SPW'(1);
            cur_node_in = child0;
            cur_hi_in   = mid;
            state_in    = S_VISIT;
         end
         S_RET: begin
            if (sp_ff == '0) begin
               state_in = S_DONE;
            end else if (!top_ph) begin
               mark        = 1'b1;
               cur_node_in = {top_node[AW-2:0], 1'b1};
               cur_lo_in   = top_mid + LW'(1);
               cur_hi_in   = top_hi;
               state_in    = S_VISIT;
            end else begin
               sp_in = spm1;
               if (op_ff != lstmas_pkg::OP_QUERY) begin
                  cur_node_in = top_node;
                  state_in    = S_CB_R0;
               end
            end
         end
         S_CB_R0: begin
            cmd.mem_rd = 1'b1;
            addr       = child0;
            state_in   = S_CB_R1;
         end
         S_CB_R1: begin
            cmd.mem_rd    = 1'b1;
            cmd.save_left = 1'b1;
            addr          = child1;
            state_in      = S_CB_WR;
         end
         S_CB_WR: begin
            cmd.mem_wr = 1'b1;
            cmd.wr_src = lstmas_pkg::WR_COMBINE;
            state_in   = S_RET;
         end
         S_DONE: begin
            if (op_ff != lstmas_pkg::OP_QUERY) begin
               state_in = S_IDLE;
            end else if (!rsp_busy) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_addr_ff <= '0;
         sp_ff       <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         sp_ff       <= sp_in;
      end
   end

   // Walk registers.
   always_ff @(posedge clock) begin
      ret_ff      <= ret_in;
      op_ff       <= op_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      cur_node_ff <= cur_node_in;
      cur_lo_ff   <= cur_lo_in;
      cur_hi_ff   <= cur_hi_in;
      ap_addr_ff  <= ap_addr_in;
      ap_len_ff   <= ap_len_in;
      ap_tsel_ff  <= ap_tsel_in;
      ap_phase_ff <= ap_phase_in;
   end

   // Stack of partly visited nodes.
   always_ff @(posedge clock) begin
      if (push) begin
         stk_node_ff[sp_ix] <= cur_node_ff;
         stk_lo_ff[sp_ix]   <= cur_lo_ff;
         stk_hi_ff[sp_ix]   <= cur_hi_ff;
         stk_ph_ff[sp_ix]   <= 1'b0;
      end
      if (mark) begin
         stk_ph_ff[top_ix] <= 1'b1;
      end
   end

endmodule

`default_nettype wire

// ===== tb/lazy_segment_tree_mul_add_sum_top_test.sv =====
// Self-checking testbench of the lazy segment tree with range multiply, add and sum.
`timescale 1ns / 1ps

module lazy_segment_tree_mul_add_sum_top_test;

   localparam int VW          = lstmas_pkg::VW;
   localparam int CNTW        = lstmas_pkg::CNTW;
   localparam int TREE_LEAVES = 1024;
   localparam int TREE_NODES  = 4 * TREE_LEAVES;
   // Cycles allowed for an update that returns nothing to finish before a register write.
   localparam int SETTLE_CYCLES = 20000;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   logic [1:0]      req_op = lstmas_pkg::OP_WRITE;
   logic [CNTW-1:0] req_left = '0;
   logic [CNTW-1:0] req_right = '0;
   logic [VW-1:0]   req_value = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   logic [VW-1:0]   rsp_range_sum;
   logic            csr_we = 1'b0;
   logic            csr_index = lstmas_pkg::REG_MODULUS;
   logic [VW-1:0]   csr_wdata = '0;

   // Shadow copy of the tree and of the registers.
   bit [VW-1:0]   tree_sum [TREE_NODES];
   bit [VW-1:0]   tree_mul [TREE_NODES];
   bit [VW-1:0]   tree_add [TREE_NODES];
   bit [VW-1:0]   shadow_modulus = 31'h7FFF_FFFF;
   bit [CNTW-1:0] shadow_count = 11'd1024;

   bit [VW-1:0] sum_expect_q [$];
   int          mismatch_count = 0;
   int          tx_idle_pct = 0;
   int          rx_idle_pct = 0;
   int          hold_ticket = 0;
   int          hold_length = 0;

   lazy_segment_tree_mul_add_sum_top #(.LEAVES(TREE_LEAVES)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_left(req_left), .req_right(req_right), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_range_sum(rsp_range_sum),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Modulus in force; zero and one both behave as one.
   function automatic longint unsigned mod_in_force();
      return (shadow_modulus < 2) ? 64'd1 : longint'(shadow_modulus);
   endfunction

   // Folds a multiply/add tag pair into one node.
   function automatic void tag_node(int node, longint unsigned len,
                                    longint unsigned mul, longint unsigned add);
      longint unsigned m;
      m = mod_in_force();
      tree_sum[node] = VW'((longint'(tree_sum[node]) * mul + len * add) % m);
      tree_mul[node] = VW'((longint'(tree_mul[node]) * mul) % m);
      tree_add[node] = VW'((longint'(tree_add[node]) * mul + add) % m);
   endfunction

   // Walks the tree depth first with an explicit stack; applies the tag pair to the
   // covered nodes, or sums them when is_sum is set. Partial nodes push their tags
   // down and, for updates, are recombined once both children are done.
   function automatic longint unsigned walk_tree(bit is_sum, int a, int b,
                                                 longint unsigned mul,
                                                 longint unsigned add);
      int st_node [128];
      int st_lo [128];
      int st_hi [128];
      bit st_back [128];
      int sp;
      int node;
      int lo;
      int hi;
      int mid;
      bit back;
      longint unsigned m;
      longint unsigned acc;
      m = mod_in_force();
      acc = 0;
      sp = 1;
      st_node[0] = 1; st_lo[0] = 1; st_hi[0] = TREE_LEAVES; st_back[0] = 1'b0;
      while (sp > 0) begin
         sp = sp - 1;
         node = st_node[sp]; lo = st_lo[sp]; hi = st_hi[sp]; back = st_back[sp];
         mid = (lo + hi) >> 1;
         if (back) begin
            tree_sum[node] = VW'((longint'(tree_sum[2*node]) + tree_sum[2*node+1]) % m);
         end else if (a > hi || b < lo) begin
            // Disjoint node: nothing to do.
         end else if (a <= lo && b >= hi) begin
            if (is_sum) acc = (acc + tree_sum[node] % m) % m;
            else tag_node(node, hi - lo + 1, mul, add);
         end else begin
            tag_node(2*node, mid - lo + 1, tree_mul[node], tree_add[node]);
            tag_node(2*node+1, hi - mid, tree_mul[node], tree_add[node]);
            tree_mul[node] = 1;
            tree_add[node] = 0;
            if (!is_sum) begin
               st_node[sp] = node; st_lo[sp] = lo; st_hi[sp] = hi; st_back[sp] = 1'b1;
               sp = sp + 1;
            end
            st_node[sp] = 2*node; st_lo[sp] = lo; st_hi[sp] = mid; st_back[sp] = 1'b0;
            sp = sp + 1;
            st_node[sp] = 2*node+1; st_lo[sp] = mid+1; st_hi[sp] = hi; st_back[sp] = 1'b0;
            sp = sp + 1;
         end
      end
      return acc;
   endfunction

   // Applies one accepted beat to the shadow tree and records any sum it returns.
   function automatic void predict_beat(logic [1:0] op, int l, int r, longint unsigned v);
      int lim;
      bit empty;
      longint unsigned m;
      longint unsigned val;
      m = mod_in_force();
      val = v % m;
      lim = (shadow_count > TREE_LEAVES) ? TREE_LEAVES : int'(shadow_count);
      if (op == lstmas_pkg::OP_WRITE) r = l;
      if (l < 1) l = 1;
      if (r > lim) r = lim;
      empty = (lim == 0) || (l > r);
      if (op == lstmas_pkg::OP_QUERY) begin
         sum_expect_q.push_back(empty ? '0 : VW'(walk_tree(1'b1, l, r, 1, 0)));
      end else if (!empty) begin
         case (op)
            lstmas_pkg::OP_WRITE: void'(walk_tree(1'b0, l, r, 0, val));
            lstmas_pkg::OP_MUL:   void'(walk_tree(1'b0, l, r, val, 0));
            default:              void'(walk_tree(1'b0, l, r, 1 % m, val));
         endcase
      end
   endfunction

   // Offers one beat, after an optional gap, and holds it until it is taken.
   task automatic send_beat(logic [1:0] op, int l, int r, logic [VW-1:0] v);
      int gap;
      gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_left  <= CNTW'(l);
      req_right <= CNTW'(r);
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      predict_beat(op, l, r, v);
   endtask

   // Drops valid, drains all sums and lets any trailing update finish.
   task automatic settle();
      req_valid <= 1'b0;
      while (sum_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [VW-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx == lstmas_pkg::REG_MODULUS) shadow_modulus = data;
      else shadow_count = data[CNTW-1:0];
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [VW-1:0] pick_value();
      case ($urandom_range(3))
         0:       return VW'($urandom);
         1:       return VW'($urandom_range(10));
         2:       return VW'(shadow_modulus - 1);
         default: return 31'h7FFF_FFFF;
      endcase
   endfunction

   function automatic int pick_index();
      int lim;
      lim = (shadow_count > TREE_LEAVES) ? TREE_LEAVES : int'(shadow_count);
      if (lim < 1) lim = 1;
      if ($urandom_range(99) < 85) return $urandom_range(1, lim);
      return $urandom_range(2047);
   endfunction

   // Field extremes and every operation at the reset settings.
   task automatic test_directed_ops();
      send_beat(lstmas_pkg::OP_WRITE, 1, 0, 31'h7FFF_FFFE);
      send_beat(lstmas_pkg::OP_WRITE, 1024, 1024, 31'h7FFF_FFFF);
      send_beat(lstmas_pkg::OP_WRITE, 512, 7, 31'h5555_5555);
      send_beat(lstmas_pkg::OP_QUERY, 1, 1024, 0);
      send_beat(lstmas_pkg::OP_ADD, 1, 1024, 31'h2AAA_AAAA);
      send_beat(lstmas_pkg::OP_MUL, 300, 700, 31'h7FFF_FFFE);
      send_beat(lstmas_pkg::OP_QUERY, 1, 1024, 0);
      send_beat(lstmas_pkg::OP_QUERY, 512, 512, 0);
      // Empty and clipped ranges, and writes outside the array.
      send_beat(lstmas_pkg::OP_QUERY, 700, 300, 0);
      send_beat(lstmas_pkg::OP_QUERY, 0, 0, 0);
      send_beat(lstmas_pkg::OP_WRITE, 0, 5, 31'd99);
      send_beat(lstmas_pkg::OP_WRITE, 2047, 2047, 31'd77);
      send_beat(lstmas_pkg::OP_ADD, 1025, 2047, 31'd5);
      send_beat(lstmas_pkg::OP_QUERY, 0, 2047, 0);
      send_beat(lstmas_pkg::OP_MUL, 1, 1024, 0);
      send_beat(lstmas_pkg::OP_QUERY, 1000, 1024, 0);
      settle();
   endtask

   // Register corners: tiny moduli, counts of zero and beyond the tree.
   task automatic test_register_corners();
      send_beat(lstmas_pkg::OP_ADD, 1, 1024, 31'h1234_5678);
      settle();
      write_reg(lstmas_pkg::REG_MODULUS, 31'd1000003);
      send_beat(lstmas_pkg::OP_QUERY, 1, 1024, 0);
      send_beat(lstmas_pkg::OP_MUL, 3, 900, 31'd7);
      send_beat(lstmas_pkg::OP_QUERY, 2, 901, 0);
      settle();
      write_reg(lstmas_pkg::REG_MODULUS, 31'd0);
      send_beat(lstmas_pkg::OP_ADD, 1, 10, 31'd3);
      send_beat(lstmas_pkg::OP_QUERY, 1, 10, 0);
      settle();
      write_reg(lstmas_pkg::REG_MODULUS, 31'd1);
      send_beat(lstmas_pkg::OP_QUERY, 1, 1024, 0);
      settle();
      write_reg(lstmas_pkg::REG_MODULUS, 31'd2);
      write_reg(lstmas_pkg::REG_COUNT, 31'd0);
      send_beat(lstmas_pkg::OP_WRITE, 1, 1, 31'd1);
      send_beat(lstmas_pkg::OP_QUERY, 1, 1024, 0);
      settle();
      write_reg(lstmas_pkg::REG_COUNT, 31'd2047);
      send_beat(lstmas_pkg::OP_WRITE, 1024, 1024, 31'd1);
      send_beat(lstmas_pkg::OP_QUERY, 1, 2047, 0);
      settle();
      write_reg(lstmas_pkg::REG_COUNT, 31'd1);
      send_beat(lstmas_pkg::OP_ADD, 1, 1024, 31'd1);
      send_beat(lstmas_pkg::OP_QUERY, 1, 1024, 0);
      settle();
   endtask

   // Receiver holds off for a long stretch while queries keep coming.
   task automatic test_result_backpressure();
      int i;
      tx_idle_pct = 0;
      hold_length = 4000;
      hold_ticket = hold_ticket + 1;
      for (i = 0; i < 12; i++) send_beat(lstmas_pkg::OP_QUERY, 1, $urandom_range(1, 8), 0);
      settle();
   endtask

   // Mostly well-formed random traffic under one idling pattern.
   task automatic test_random_traffic(int beats, int tx_pct, int rx_pct);
      int i;
      int l;
      int r;
      logic [1:0] op;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      for (i = 0; i < beats; i++) begin
         op = 2'($urandom_range(3));
         l = pick_index();
         r = pick_index();
         if (l > r && $urandom_range(99) < 80) begin
            l = l ^ r; r = l ^ r; l = l ^ r;
         end
         send_beat(op, l, r, pick_value());
      end
      settle();
   endtask

   // Receiver: random ready, plus long hold-offs on request.
   always @(posedge clock) begin
      static int hold_left = 0;
      static int hold_seen = 0;
      if (hold_ticket != hold_seen) begin
         hold_seen = hold_ticket;
         hold_left = hold_length;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Compares each returned sum with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (sum_expect_q.size() == 0) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10) $display("Unexpected sum beat %0d", rsp_range_sum);
         end else begin
            if (rsp_range_sum !== sum_expect_q[0]) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("range_sum mismatch: expected %0d, got %0d",
                           sum_expect_q[0], rsp_range_sum);
            end
            void'(sum_expect_q.pop_front());
         end
      end
   end

   initial begin
      int i;
      for (i = 0; i < TREE_NODES; i++) begin
         tree_sum[i] = 0; tree_mul[i] = 1; tree_add[i] = 0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_ops();
      test_register_corners();
      test_result_backpressure();
      write_reg(lstmas_pkg::REG_MODULUS, 31'h7FFF_FFFF);
      write_reg(lstmas_pkg::REG_COUNT, 31'd1024);
      test_random_traffic(350, 31, 66);
      write_reg(lstmas_pkg::REG_MODULUS, 31'd1000003);
      write_reg(lstmas_pkg::REG_COUNT, 31'd16);
      test_random_traffic(350, 66, 31);
      write_reg(lstmas_pkg::REG_MODULUS, 31'($urandom_range(2, 32'h7FFF_FFFF)));
      write_reg(lstmas_pkg::REG_COUNT, 31'($urandom_range(1, 1024)));
      test_random_traffic(350, 0, 0);
      if (mismatch_count == 0 && sum_expect_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #400ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== lazy_segment_tree_mul_add_sum_top.f =====
rtl/lstmas_pkg.sv
rtl/lstmas_mulmod.sv
rtl/lstmas_datapath.sv
rtl/lstmas_ctrl.sv
rtl/lazy_segment_tree_mul_add_sum_top.sv
tb/lazy_segment_tree_mul_add_sum_top_test.sv
